// ----- rtl/lpd_pkg.sv -----
package lpd_pkg;

    localparam int BUFFER_DEPTH_DEF       = 128;
    localparam int HEADER_BYTES_DEF       = 5;
    localparam int START_ANGLE_OFFSET_DEF = 5;
    localparam int END_ANGLE_OFFSET_DEF   = 40;

    localparam logic [7:0] SYNC_FIRST    = 8'hA5;
    localparam logic [7:0] SYNC_SECOND   = 8'h5A;
    localparam logic [7:0] MIN_LEN_RESET = 8'd102;
    localparam logic [7:0] MAX_LEN_RESET = 8'd108;

    localparam int LEN_LO_INDEX    = 2;
    localparam int LEN_READY_COUNT = 5;
    localparam int POINT_COUNT     = 16;
    localparam int POINT_BASE      = 7;
    localparam int ANGLE_STEPS     = 4;
    localparam int LAST_STEP       = ANGLE_STEPS + 2 * POINT_COUNT;
    localparam int POINT_SPAN_END  = POINT_BASE + 2 * POINT_COUNT + 1;

    localparam logic [3:0] LAST_POINT_INDEX = 4'(POINT_COUNT - 1);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_DATA,
        PH_CHECK
    } t_phase;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_ISSUE,
        SQ_CAPTURE
    } t_seq_state;

    typedef enum logic {
        REG_MIN_LEN = 1'b0,
        REG_MAX_LEN = 1'b1
    } t_cfg_reg;

endpackage

// ----- rtl/lidar_packet_deframer.sv -----
// Channel   | Handshake               | Payload
// ----------+-------------------------+----------------------------------------------
// input     | i_valid / o_ready       | i_rx_byte
// output    | o_valid / i_ready       | o_point_index, o_range_raw, o_intensity,
//           |                         | o_angle_start, o_angle_end, o_last_point
// config    | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// A received byte is written to the frame memory and parsed in the same cycle.
// After a good frame the input is held off while the point sequencer reads
// 37 bytes through the single read port of the frame memory, issuing each
// read and then capturing its data, to build a burst of 16 points.
// Output stalls hold the sequencer before the read that closes each point.
// Reset is synchronous and active low; the frame memory is not cleared.
module lidar_packet_deframer import lpd_pkg::*; #(
    parameter int BUFFER_DEPTH       = BUFFER_DEPTH_DEF,
    parameter int HEADER_BYTES       = HEADER_BYTES_DEF,
    parameter int START_ANGLE_OFFSET = START_ANGLE_OFFSET_DEF,
    parameter int END_ANGLE_OFFSET   = END_ANGLE_OFFSET_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_point_index,
    output logic [15:0] o_range_raw,
    output logic [7:0]  o_intensity,
    output logic [15:0] o_angle_start,
    output logic [15:0] o_angle_end,
    output logic        o_last_point,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic          s_wr_en;
    logic [AW-1:0] s_wr_addr;
    logic [7:0]    s_wr_data;
    logic          s_rd_en;
    logic [AW-1:0] s_rd_addr;
    logic [7:0]    s_rd_data;
    logic          s_start;
    logic          s_busy;

    assign o_cfg_ready = 1'b1;

    lpd_parser #(
        .BUFFER_DEPTH       (BUFFER_DEPTH),
        .HEADER_BYTES       (HEADER_BYTES),
        .START_ANGLE_OFFSET (START_ANGLE_OFFSET),
        .END_ANGLE_OFFSET   (END_ANGLE_OFFSET)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_rx_byte   (i_rx_byte),
        .i_busy      (s_busy),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_ready     (o_ready),
        .o_wr_en     (s_wr_en),
        .o_wr_addr   (s_wr_addr),
        .o_wr_data   (s_wr_data),
        .o_start     (s_start)
    );

    lpd_frame_mem #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (s_wr_en),
        .i_wr_addr (s_wr_addr),
        .i_wr_data (s_wr_data),
        .i_rd_en   (s_rd_en),
        .i_rd_addr (s_rd_addr),
        .o_rd_data (s_rd_data)
    );

    lpd_point_seq #(
        .BUFFER_DEPTH       (BUFFER_DEPTH),
        .START_ANGLE_OFFSET (START_ANGLE_OFFSET),
        .END_ANGLE_OFFSET   (END_ANGLE_OFFSET)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (s_start),
        .i_rd_data     (s_rd_data),
        .i_ready       (i_ready),
        .o_rd_en       (s_rd_en),
        .o_rd_addr     (s_rd_addr),
        .o_busy        (s_busy),
        .o_valid       (o_valid),
        .o_point_index (o_point_index),
        .o_range_raw   (o_range_raw),
        .o_intensity   (o_intensity),
        .o_angle_start (o_angle_start),
        .o_angle_end   (o_angle_end),
        .o_last_point  (o_last_point)
    );

endmodule

// ----- rtl/lpd_frame_mem.sv -----
module lpd_frame_mem import lpd_pkg::*; #(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
    localparam int AW = $clog2(BUFFER_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [BUFFER_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/lpd_parser.sv -----
module lpd_parser import lpd_pkg::*; #(
    parameter int BUFFER_DEPTH       = BUFFER_DEPTH_DEF,
    parameter int HEADER_BYTES       = HEADER_BYTES_DEF,
    parameter int START_ANGLE_OFFSET = START_ANGLE_OFFSET_DEF,
    parameter int END_ANGLE_OFFSET   = END_ANGLE_OFFSET_DEF,
    localparam int AW = $clog2(BUFFER_DEPTH),
    localparam int CW = $clog2(BUFFER_DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_rx_byte,
    input  logic          i_busy,
    input  logic          i_cfg_valid,
    input  logic [0:0]    i_cfg_index,
    input  logic [7:0]    i_cfg_data,
    output logic          o_ready,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output logic [7:0]    o_wr_data,
    output logic          o_start
);

    localparam int NEED_A = (START_ANGLE_OFFSET + 2 > POINT_SPAN_END) ?
                            START_ANGLE_OFFSET + 2 : POINT_SPAN_END;
    localparam int NEED_BYTES = (END_ANGLE_OFFSET + 2 > NEED_A) ? END_ANGLE_OFFSET + 2 : NEED_A;

    t_phase        r_phase, n_phase;
    logic [CW-1:0] r_count, n_count;
    logic [7:0]    r_sum, n_sum;
    logic [15:0]   r_len, n_len;
    logic [7:0]    r_prev, n_prev;
    logic [7:0]    r_len_lo, n_len_lo;
    logic          r_start, n_start;
    logic [7:0]    r_min_len, r_max_len;

    logic          s_accept;
    logic          s_full;
    logic [CW-1:0] s_base_count;
    logic [CW-1:0] s_cnt_inc;
    logic [7:0]    s_base_sum;
    t_phase        s_base_phase;
    logic [15:0]   s_len;

    // A byte arriving on a full buffer restarts the frame with itself as byte zero.
    assign s_accept     = i_valid && o_ready;
    assign s_full       = (r_count == CW'(BUFFER_DEPTH));
    assign s_base_count = s_full ? '0 : r_count;
    assign s_base_sum   = s_full ? 8'd0 : r_sum;
    assign s_base_phase = s_full ? PH_HEADER : r_phase;
    assign s_cnt_inc    = s_base_count + CW'(1);
    assign s_len        = {r_prev, r_len_lo};

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_sum    = r_sum;
        n_len    = r_len;
        n_prev   = r_prev;
        n_len_lo = r_len_lo;
        n_start  = 1'b0;
        if (s_accept) begin
            n_count = s_cnt_inc;
            n_sum   = s_base_sum + i_rx_byte;
            n_phase = s_base_phase;
            n_prev  = i_rx_byte;
            if (s_base_count == CW'(LEN_LO_INDEX)) begin
                n_len_lo = i_rx_byte;
            end
            unique case (s_base_phase)
                PH_HEADER: begin
                    if (s_cnt_inc >= CW'(2)) begin
                        if (r_prev == SYNC_FIRST && i_rx_byte == SYNC_SECOND) begin
                            n_phase = PH_LENGTH;
                        end else begin
                            n_count = '0;
                            n_sum   = 8'd0;
                            n_phase = PH_HEADER;
                        end
                    end
                end
                PH_LENGTH: begin
                    if (s_cnt_inc >= CW'(LEN_READY_COUNT)) begin
                        n_len = s_len;
                        if (s_len >= {8'd0, r_min_len} && s_len <= {8'd0, r_max_len}) begin
                            n_phase = PH_DATA;
                        end else begin
                            n_count = '0;
                            n_sum   = 8'd0;
                            n_phase = PH_HEADER;
                        end
                    end
                end
                PH_DATA: begin
                    if (s_cnt_inc > CW'(HEADER_BYTES) &&
                        (17'(s_cnt_inc) + 17'd1) >= {1'b0, r_len}) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    n_start = (s_base_sum == i_rx_byte) && (s_cnt_inc >= CW'(NEED_BYTES));
                    n_count = '0;
                    n_sum   = 8'd0;
                    n_phase = PH_HEADER;
                end
                default: begin
                    n_phase = PH_HEADER;
                end
            endcase
        end
    end

    always_comb begin
        o_ready   = !i_busy && !r_start;
        o_wr_en   = s_accept;
        o_wr_addr = s_base_count[AW-1:0];
        o_wr_data = i_rx_byte;
        o_start   = r_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_count <= '0;
            r_sum   <= 8'd0;
            r_len   <= 16'd0;
            r_start <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_len   <= n_len;
            r_start <= n_start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev   <= n_prev;
        r_len_lo <= n_len_lo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= MIN_LEN_RESET;
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_MIN_LEN: r_min_len <= i_cfg_data;
                REG_MAX_LEN: r_max_len <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ----- rtl/lpd_point_seq.sv -----
module lpd_point_seq import lpd_pkg::*; #(
    parameter int BUFFER_DEPTH       = BUFFER_DEPTH_DEF,
    parameter int START_ANGLE_OFFSET = START_ANGLE_OFFSET_DEF,
    parameter int END_ANGLE_OFFSET   = END_ANGLE_OFFSET_DEF,
    localparam int AW = $clog2(BUFFER_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [7:0]    i_rd_data,
    input  logic          i_ready,
    output logic          o_rd_en,
    output logic [AW-1:0] o_rd_addr,
    output logic          o_busy,
    output logic          o_valid,
    output logic [3:0]    o_point_index,
    output logic [15:0]   o_range_raw,
    output logic [7:0]    o_intensity,
    output logic [15:0]   o_angle_start,
    output logic [15:0]   o_angle_end,
    output logic          o_last_point
);

    localparam int SW = $clog2(LAST_STEP + 1);

    t_seq_state  r_state, n_state;
    logic [SW-1:0] r_step, n_step;
    logic [3:0]  r_pt, n_pt;
    logic [15:0] r_a0, n_a0;
    logic [15:0] r_a1, n_a1;
    logic [7:0]  r_b0, n_b0;
    logic [7:0]  r_b1, n_b1;
    logic        r_valid, n_valid;
    logic [3:0]  r_out_pt, n_out_pt;
    logic [15:0] r_out_range, n_out_range;
    logic [7:0]  r_out_inten, n_out_inten;
    logic [15:0] r_out_a0, n_out_a0;
    logic [15:0] r_out_a1, n_out_a1;
    logic        r_out_last, n_out_last;

    logic        s_completes;
    logic [8:0]  s_addr;

    // Bytes 7 to 39 are read in order; each odd byte from 9 on closes one point.
    assign s_completes = (r_step >= SW'(ANGLE_STEPS + 2)) && !r_step[0];

    always_comb begin
        case (r_step)
            SW'(0):  s_addr = 9'(START_ANGLE_OFFSET);
            SW'(1):  s_addr = 9'(START_ANGLE_OFFSET + 1);
            SW'(2):  s_addr = 9'(END_ANGLE_OFFSET);
            SW'(3):  s_addr = 9'(END_ANGLE_OFFSET + 1);
            default: s_addr = 9'(POINT_BASE) + 9'(r_step) - 9'(ANGLE_STEPS);
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_pt        = r_pt;
        n_a0        = r_a0;
        n_a1        = r_a1;
        n_b0        = r_b0;
        n_b1        = r_b1;
        n_valid     = r_valid && !i_ready;
        n_out_pt    = r_out_pt;
        n_out_range = r_out_range;
        n_out_inten = r_out_inten;
        n_out_a0    = r_out_a0;
        n_out_a1    = r_out_a1;
        n_out_last  = r_out_last;
        unique case (r_state)
            SQ_IDLE: begin
                if (i_start) begin
                    n_state = SQ_ISSUE;
                    n_step  = '0;
                    n_pt    = 4'd0;
                end
            end
            SQ_ISSUE: begin
                if (!(s_completes && r_valid)) begin
                    n_state = SQ_CAPTURE;
                end
            end
            SQ_CAPTURE: begin
                case (r_step)
                    SW'(0): n_a0[15:8] = i_rd_data;
                    SW'(1): n_a0[7:0]  = i_rd_data;
                    SW'(2): n_a1[15:8] = i_rd_data;
                    SW'(3): n_a1[7:0]  = i_rd_data;
                    default: begin
                        n_b0 = r_b1;
                        n_b1 = i_rd_data;
                    end
                endcase
                if (s_completes) begin
                    n_valid     = 1'b1;
                    n_out_pt    = r_pt;
                    n_out_range = {r_b0, r_b1};
                    n_out_inten = i_rd_data;
                    n_out_a0    = r_a0;
                    n_out_a1    = r_a1;
                    n_out_last  = (r_pt == LAST_POINT_INDEX);
                    n_pt        = r_pt + 4'd1;
                end
                if (r_step == SW'(LAST_STEP)) begin
                    n_state = SQ_IDLE;
                end else begin
                    n_step  = r_step + SW'(1);
                    n_state = SQ_ISSUE;
                end
            end
            default: n_state = SQ_IDLE;
        endcase
    end

    always_comb begin
        o_rd_en       = (r_state == SQ_ISSUE) && !(s_completes && r_valid);
        o_rd_addr     = s_addr[AW-1:0];
        o_busy        = (r_state != SQ_IDLE);
        o_valid       = r_valid;
        o_point_index = r_out_pt;
        o_range_raw   = r_out_range;
        o_intensity   = r_out_inten;
        o_angle_start = r_out_a0;
        o_angle_end   = r_out_a1;
        o_last_point  = r_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SQ_IDLE;
            r_step  <= '0;
            r_pt    <= 4'd0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_pt    <= n_pt;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a0        <= n_a0;
        r_a1        <= n_a1;
        r_b0        <= n_b0;
        r_b1        <= n_b1;
        r_out_pt    <= n_out_pt;
        r_out_range <= n_out_range;
        r_out_inten <= n_out_inten;
        r_out_a0    <= n_out_a0;
        r_out_a1    <= n_out_a1;
        r_out_last  <= n_out_last;
    end

endmodule

// ----- rtl/lpd_checker.sv -----
module lpd_checker import lpd_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [3:0]  o_point_index,
    input logic [15:0] o_range_raw,
    input logic [7:0]  o_intensity,
    input logic [15:0] o_angle_start,
    input logic [15:0] o_angle_end,
    input logic        o_last_point
);

    logic [3:0] r_exp_pt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_pt <= 4'd0;
        end else if (o_valid && i_ready) begin
            r_exp_pt <= r_exp_pt + 4'd1;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_point_index) && $stable(o_range_raw) &&
        $stable(o_intensity) && $stable(o_angle_start) && $stable(o_angle_end) &&
        $stable(o_last_point))
        else $error("output changed during a stalled transfer");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_last_point == (o_point_index == LAST_POINT_INDEX))
        else $error("last point flag does not match point index");

    a_burst_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_point |-> !o_ready)
        else $error("input accepted in the middle of a point burst");

    a_point_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready |-> o_point_index == r_exp_pt)
        else $error("point index out of sequence");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind lidar_packet_deframer lpd_checker u_checker (.*);

// ----- verif/lidar_packet_deframer_tb.sv -----
module lidar_packet_deframer_tb import lpd_pkg::*; ();

    localparam int SETTLE_CYCLES  = 100;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int ANGLE_SPAN_END = ((START_ANGLE_OFFSET_DEF > END_ANGLE_OFFSET_DEF) ?
                                     START_ANGLE_OFFSET_DEF : END_ANGLE_OFFSET_DEF) + 2;
    localparam int POINTS_NEED    = (POINT_SPAN_END > ANGLE_SPAN_END) ?
                                     POINT_SPAN_END : ANGLE_SPAN_END;

    typedef struct packed {
        logic [3:0]  point_index;
        logic [15:0] range_raw;
        logic [7:0]  intensity;
        logic [15:0] angle_start;
        logic [15:0] angle_end;
        logic        last_point;
    } t_point;

    typedef enum {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } t_fill;

    class point_scoreboard;
        logic [7:0] frame_bytes [BUFFER_DEPTH_DEF];
        int         held_count;
        t_phase     phase;
        int         length_field;
        logic [7:0] byte_sum;
        int         min_len;
        int         max_len;
        t_point     expected_points [$];
        int         errors;

        function new();
            held_count       = 0;
            phase            = PH_HEADER;
            length_field     = 0;
            byte_sum         = 8'd0;
            min_len          = MIN_LEN_RESET;
            max_len          = MAX_LEN_RESET;
            errors           = 0;
        endfunction

        function void set_limit(t_cfg_reg idx, logic [7:0] value);
            if (idx == REG_MIN_LEN) begin
                min_len = value;
            end else begin
                max_len = value;
            end
        endfunction

        function void restart_frame();
            held_count = 0;
            byte_sum   = 8'd0;
            phase      = PH_HEADER;
        endfunction

        function logic [15:0] word_at(int idx);
            return {frame_bytes[idx], frame_bytes[idx + 1]};
        endfunction

        function void note_byte(logic [7:0] rx);
            logic [7:0] sum_before;
            t_point     p;
            int         i;
            if (held_count >= BUFFER_DEPTH_DEF) begin
                restart_frame();
            end
            sum_before              = byte_sum;
            frame_bytes[held_count] = rx;
            held_count++;
            byte_sum                = byte_sum + rx;
            case (phase)
                PH_HEADER: begin
                    if (held_count >= 2) begin
                        if (frame_bytes[0] == SYNC_FIRST && frame_bytes[1] == SYNC_SECOND) begin
                            phase = PH_LENGTH;
                        end else begin
                            restart_frame();
                        end
                    end
                end
                PH_LENGTH: begin
                    if (held_count >= LEN_READY_COUNT) begin
                        length_field = {frame_bytes[LEN_LO_INDEX + 1], frame_bytes[LEN_LO_INDEX]};
                        if (length_field >= min_len && length_field <= max_len) begin
                            phase = PH_DATA;
                        end else begin
                            restart_frame();
                        end
                    end
                end
                PH_DATA: begin
                    if (held_count > HEADER_BYTES_DEF && held_count + 1 >= length_field) begin
                        phase = PH_CHECK;
                    end
                end
                default: begin
                    // A frame too short for every point and angle field yields nothing.
                    if (sum_before == rx && held_count >= POINTS_NEED) begin
                        for (i = 0; i < POINT_COUNT; i++) begin
                            p.point_index = 4'(i);
                            p.range_raw   = word_at(POINT_BASE + 2 * i);
                            p.intensity   = frame_bytes[POINT_BASE + 2 * i + 2];
                            p.angle_start = word_at(START_ANGLE_OFFSET_DEF);
                            p.angle_end   = word_at(END_ANGLE_OFFSET_DEF);
                            p.last_point  = (i == POINT_COUNT - 1);
                            expected_points.push_back(p);
                        end
                    end
                    restart_frame();
                end
            endcase
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_point(t_point got);
            t_point want;
            if (expected_points.size() == 0) begin
                $display("%0t: point expected none actual index %0d range %0d",
                         $time, got.point_index, got.range_raw);
                errors++;
                return;
            end
            want = expected_points.pop_front();
            compare("point_index", want.point_index, got.point_index);
            compare("range_raw", want.range_raw, got.range_raw);
            compare("intensity", want.intensity, got.intensity);
            compare("angle_start", want.angle_start, got.angle_start);
            compare("angle_end", want.angle_end, got.angle_end);
            compare("last_point", want.last_point, got.last_point);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_ready;
    logic [7:0]  i_rx_byte   = 8'd0;
    logic        o_valid;
    logic        i_ready     = 1'b0;
    logic [3:0]  o_point_index;
    logic [15:0] o_range_raw;
    logic [7:0]  o_intensity;
    logic [15:0] o_angle_start;
    logic [15:0] o_angle_end;
    logic        o_last_point;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index = REG_MIN_LEN;
    logic [7:0]  i_cfg_data  = 8'd0;

    point_scoreboard sb;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int quiet_cycles = 0;

    lidar_packet_deframer DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        t_point got;
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                sb.set_limit(t_cfg_reg'(i_cfg_index), i_cfg_data);
            end
            if (i_valid && o_ready) begin
                sb.note_byte(i_rx_byte);
            end
            if (o_valid && i_ready) begin
                got.point_index = o_point_index;
                got.range_raw   = o_range_raw;
                got.intensity   = o_intensity;
                got.angle_start = o_angle_start;
                got.angle_end   = o_angle_end;
                got.last_point  = o_last_point;
                sb.check_point(got);
            end
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("lidar_packet_deframer_tb NOT OK");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] value);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= value;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain(input int settle);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_points.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic set_limits(input logic [7:0] lo, input logic [7:0] hi);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_MIN_LEN;
        i_cfg_data  <= lo;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= REG_MAX_LEN;
        i_cfg_data  <= hi;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // The last byte carries the checksum once the frame is longer than its header.
    task automatic send_frame(input int len, input int nbytes, input bit corrupt, input t_fill fill);
        logic [7:0] value;
        logic [7:0] sum;
        int         k;
        sum = 8'd0;
        for (k = 0; k < nbytes; k++) begin
            case (k)
                0: value = SYNC_FIRST;
                1: value = SYNC_SECOND;
                2: value = len[7:0];
                3: value = len[15:8];
                default: begin
                    if (fill == FILL_ZERO) begin
                        value = 8'h00;
                    end else if (fill == FILL_ONES) begin
                        value = 8'hFF;
                    end else begin
                        value = 8'($urandom);
                    end
                end
            endcase
            if (k == nbytes - 1 && k >= LEN_READY_COUNT) begin
                value = corrupt ? sum + 8'(1 + $urandom_range(0, 254)) : sum;
            end
            send_byte(value);
            sum = sum + value;
        end
    endtask

    initial begin
        sb = new();
        tx_idle_pct = 32;
        rx_idle_pct = 80;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_frame(MIN_LEN_RESET - 1, LEN_READY_COUNT, 1'b0, FILL_RANDOM);
        send_frame(MAX_LEN_RESET + 1, LEN_READY_COUNT, 1'b0, FILL_RANDOM);
        drain(SETTLE_CYCLES);

        set_limits(8'd0, 8'd128);
        send_frame(0, 7, 1'b0, FILL_ZERO);
        send_frame(POINTS_NEED, POINTS_NEED, 1'b0, FILL_RANDOM);
        drain(SETTLE_CYCLES);

        tx_idle_pct = 80;
        rx_idle_pct = 32;
        // With the limits inverted every length is refused.
        set_limits(8'd128, 8'd0);
        send_frame(64, LEN_READY_COUNT, 1'b0, FILL_RANDOM);
        drain(SETTLE_CYCLES);
        set_limits(8'(POINTS_NEED), 8'(POINTS_NEED + 8));
        send_frame(POINTS_NEED, POINTS_NEED, 1'b1, FILL_ONES);
        drain(SETTLE_CYCLES);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_frame(POINTS_NEED, POINTS_NEED, 1'b0, FILL_RANDOM);
        drain(SETTLE_CYCLES);

        if (sb.errors == 0 && sb.expected_points.size() == 0) begin
            $display("lidar_packet_deframer_tb OK");
        end else begin
            $display("lidar_packet_deframer_tb NOT OK");
        end
        $finish;
    end

endmodule
